// ===== rtl/kvl_pkg.sv =====
//==============================================================================
// kvl_pkg
// Shared types and constants for the keyframe vector interpolator.
//==============================================================================
package kvl_pkg;

    localparam int MAX_KEYS = 64;
    localparam int IDX_W    = $clog2(MAX_KEYS);
    localparam int CNT_W    = 7;
    localparam int QDEPTH   = 2;

    typedef enum logic
    {
        OP_LOAD   = 1'b0,
        OP_SAMPLE = 1'b1
    } op_t;

    // item passed from front to back
    typedef struct packed
    {
        op_t              op;
        logic [IDX_W-1:0] idx;
        logic [31:0]      ktime;
        logic [31:0]      vx;
        logic [31:0]      vy;
        logic [31:0]      vz;
        logic [31:0]      stime;
    } item_t;

endpackage

// ===== rtl/kvl_ram.sv =====
//==============================================================================
// kvl_ram
// Generic single-port write, single-port read RAM with registered read.
//==============================================================================
module kvl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/kvl_front.sv =====
//==============================================================================
// kvl_front
// Accepts command items and queues them for the back end.
//==============================================================================
module kvl_front
    import kvl_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output logic  empty,
    output item_t head
);

    localparam int PW = $clog2(QDEPTH);

    item_t         q_reg [QDEPTH];
    logic [PW-1:0] wp_reg, rp_reg;
    logic [PW:0]   cnt_reg;

    assign full  = (cnt_reg == (PW+1)'(QDEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = q_reg[rp_reg];

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg] <= push_item;
        end
    end

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (pop)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (PW+1)'(push) - (PW+1)'(pop);
        end
    end

endmodule

// ===== rtl/kvl_back.sv =====
//==============================================================================
// kvl_back
// Sequencer: table writes, wrap modulo, key search, factor divide, blend.
//==============================================================================
module kvl_back
    import kvl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              empty,
    input  item_t             head,
    output logic              pop,
    input  logic [CNT_W-1:0]  key_count,
    output logic              done,
    output logic [31:0]       out_x,
    output logic [31:0]       out_y,
    output logic [31:0]       out_z,
    output logic              status
);

    typedef enum logic [3:0]
    {
        S_IDLE, S_RD0, S_RDL, S_CHK, S_MOD, S_ADD, S_SRCH, S_RDLO,
        S_GETLO, S_DIV, S_BL, S_BLW, S_OUT
    } state_t;

    state_t            st_reg;
    item_t             it_reg;
    logic [IDX_W:0]    n_reg;
    logic [IDX_W-1:0]  ra_reg;
    logic [IDX_W-1:0]  i_reg;
    logic [31:0]       t0_reg, span_reg, t_reg, lo_reg, den_reg;
    logic [47:0]       rem_reg;
    logic [5:0]        cnt_reg;
    logic [47:0]       num_reg;
    logic [16:0]       f_reg;
    logic [1:0]        c_reg;
    logic              srch_rd_reg;
    logic [31:0]       a_reg [3];
    logic [31:0]       b_reg [3];
    logic [31:0]       res_reg [3];
    logic              done_reg, status_reg;

    logic [31:0] t_rd, x_rd, y_rd, z_rd;
    logic        we;
    logic [IDX_W-1:0] raddr;

    assign we    = (st_reg == S_IDLE) && !empty && (head.op == OP_LOAD);
    assign pop   = (st_reg == S_IDLE) && !empty;
    assign raddr = ra_reg;
    assign done  = done_reg;
    assign status = status_reg;
    assign out_x = res_reg[0];
    assign out_y = res_reg[1];
    assign out_z = res_reg[2];

    kvl_ram #(.WIDTH(32), .DEPTH(MAX_KEYS)) u_t (.clk(clk), .we(we), .waddr(head.idx),
        .wdata(head.ktime), .raddr(raddr), .rdata(t_rd));
    kvl_ram #(.WIDTH(32), .DEPTH(MAX_KEYS)) u_x (.clk(clk), .we(we), .waddr(head.idx),
        .wdata(head.vx), .raddr(raddr), .rdata(x_rd));
    kvl_ram #(.WIDTH(32), .DEPTH(MAX_KEYS)) u_y (.clk(clk), .we(we), .waddr(head.idx),
        .wdata(head.vy), .raddr(raddr), .rdata(y_rd));
    kvl_ram #(.WIDTH(32), .DEPTH(MAX_KEYS)) u_z (.clk(clk), .we(we), .waddr(head.idx),
        .wdata(head.vz), .raddr(raddr), .rdata(z_rd));

    // restoring divide steps for modulo and factor
    logic [32:0] mod_trial;
    logic [48:0] div_trial;
    assign mod_trial = {rem_reg[31:0], it_reg.stime[31]} - {1'b0, span_reg};
    assign div_trial = {rem_reg[47:0], num_reg[47]} - {17'b0, den_reg};

    // blend of one component
    logic signed [32:0] d_s;
    logic signed [50:0] prod;
    logic signed [34:0] q_s;
    logic [1:0]         cc;
    assign cc   = c_reg;
    assign d_s  = $signed({b_reg[cc][31], b_reg[cc]}) - $signed({a_reg[cc][31], a_reg[cc]});
    assign prod = d_s * $signed({1'b0, f_reg});
    assign q_s  = 35'(prod >>> 16);

    // effective key count
    logic [IDX_W:0] n_eff;
    always_comb
    begin
        if (key_count == '0)
        begin
            n_eff = (IDX_W+1)'(1);
        end
        else if (key_count > CNT_W'(MAX_KEYS))
        begin
            n_eff = (IDX_W+1)'(MAX_KEYS);
        end
        else
        begin
            n_eff = (IDX_W+1)'(key_count);
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg      <= S_IDLE;
            done_reg    <= 1'b0;
            status_reg  <= 1'b0;
            ra_reg      <= '0;
            srch_rd_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (st_reg)
                S_IDLE:
                begin
                    if (!empty && head.op == OP_SAMPLE)
                    begin
                        it_reg <= head;
                        n_reg  <= n_eff;
                        ra_reg <= '0;
                        st_reg <= S_RD0;
                    end
                end
                S_RD0:
                begin
                    ra_reg <= IDX_W'(n_reg - 1'b1);
                    st_reg <= S_RDL;
                end
                S_RDL:
                begin
                    // key 0 data arrives
                    t0_reg   <= t_rd;
                    a_reg[0] <= x_rd;
                    a_reg[1] <= y_rd;
                    a_reg[2] <= z_rd;
                    st_reg   <= S_CHK;
                end
                S_CHK:
                begin
                    if (n_reg == (IDX_W+1)'(1))
                    begin
                        res_reg[0] <= a_reg[0];
                        res_reg[1] <= a_reg[1];
                        res_reg[2] <= a_reg[2];
                        status_reg <= 1'b0;
                        st_reg     <= S_OUT;
                    end
                    else if (t_rd <= t0_reg)
                    begin
                        res_reg[0] <= '0;
                        res_reg[1] <= '0;
                        res_reg[2] <= '0;
                        status_reg <= 1'b1;
                        st_reg     <= S_OUT;
                    end
                    else
                    begin
                        span_reg <= t_rd - t0_reg;
                        rem_reg  <= '0;
                        cnt_reg  <= '0;
                        st_reg   <= S_MOD;
                    end
                end
                S_MOD:
                begin
                    // one quotient bit per cycle, remainder only
                    if (!mod_trial[32])
                    begin
                        rem_reg[31:0] <= mod_trial[31:0];
                    end
                    else
                    begin
                        rem_reg[31:0] <= {rem_reg[30:0], it_reg.stime[31]};
                    end
                    it_reg.stime <= {it_reg.stime[30:0], 1'b0};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 6'd31)
                    begin
                        st_reg <= S_ADD;
                    end
                end
                S_ADD:
                begin
                    t_reg       <= rem_reg[31:0] + t0_reg;
                    i_reg       <= '0;
                    ra_reg      <= IDX_W'(1);
                    srch_rd_reg <= 1'b0;
                    st_reg      <= S_SRCH;
                end
                S_SRCH:
                begin
                    // each table entry takes an address step, then a compare step
                    if (!srch_rd_reg)
                    begin
                        srch_rd_reg <= 1'b1;
                    end
                    else
                    begin
                        srch_rd_reg <= 1'b0;
                        if (t_reg < t_rd || (IDX_W+1)'(i_reg) + 2'd2 >= n_reg)
                        begin
                            ra_reg <= i_reg;
                            den_reg <= t_rd;
                            b_reg[0] <= x_rd;
                            b_reg[1] <= y_rd;
                            b_reg[2] <= z_rd;
                            st_reg <= S_RDLO;
                        end
                        else
                        begin
                            i_reg  <= i_reg + 1'b1;
                            ra_reg <= IDX_W'(i_reg + 2'd2);
                        end
                    end
                end
                S_RDLO:
                begin
                    st_reg <= S_GETLO;
                end
                S_GETLO:
                begin
                    lo_reg   <= t_rd;
                    den_reg  <= den_reg - t_rd;
                    num_reg  <= {t_reg - t_rd, 16'b0};
                    a_reg[0] <= x_rd;
                    a_reg[1] <= y_rd;
                    a_reg[2] <= z_rd;
                    rem_reg  <= '0;
                    cnt_reg  <= '0;
                    st_reg   <= S_DIV;
                end
                S_DIV:
                begin
                    // 48-bit dividend, quotient shifted into num_reg
                    if (!div_trial[48])
                    begin
                        rem_reg[47:0] <= div_trial[47:0];
                        num_reg <= {num_reg[46:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg[47:0] <= {rem_reg[46:0], num_reg[47]};
                        num_reg <= {num_reg[46:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 6'd47)
                    begin
                        st_reg <= S_BL;
                    end
                end
                S_BL:
                begin
                    f_reg  <= {1'b0, num_reg[15:0]};
                    c_reg  <= '0;
                    st_reg <= S_BLW;
                end
                S_BLW:
                begin
                    // floor shift gives round toward minus infinity
                    res_reg[c_reg] <= 32'(35'($signed({{3{a_reg[c_reg][31]}},
                        a_reg[c_reg]})) + q_s);
                    status_reg <= 1'b0;
                    c_reg <= c_reg + 1'b1;
                    if (c_reg == 2'd2)
                    begin
                        st_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    done_reg <= 1'b1;
                    st_reg   <= S_IDLE;
                end
                default:
                begin
                    st_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/keyframe_vector_lerp.sv =====
//==============================================================================
// keyframe_vector_lerp
// Keyframe table with Q16.16 linear interpolation of a three-component vector.
//==============================================================================
// Load items are written to the key table in the same cycle that they leave the
// item queue. A sample's done strobe waits on the 32-step wrap modulo, the key
// search over the registered key table read and the 48-step factor divider; a
// single key, or a last key time not after the first, skips all three. One
// result comes out per sample on done for a single cycle; it cannot be stalled.
// A two-entry item queue keeps busy low while the back end works until two
// items wait.
module keyframe_vector_lerp
    import kvl_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    output logic         busy,
    input  logic         operation,
    input  logic [5:0]   key_index,
    input  logic [31:0]  key_time,
    input  logic [31:0]  value_x,
    input  logic [31:0]  value_y,
    input  logic [31:0]  value_z,
    input  logic [31:0]  sample_time,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [6:0]   cfg_data,
    output logic         done,
    output logic [31:0]  out_x,
    output logic [31:0]  out_y,
    output logic [31:0]  out_z,
    output logic         status
);

    logic [CNT_W-1:0] kc_reg;
    item_t in_item, head;
    logic  full, empty, pop;

    assign busy      = full;
    assign cfg_ready = 1'b1;

    // pack item
    always_comb
    begin
        in_item.op    = op_t'(operation);
        in_item.idx   = IDX_W'(key_index);
        in_item.ktime = key_time;
        in_item.vx    = value_x;
        in_item.vy    = value_y;
        in_item.vz    = value_z;
        in_item.stime = sample_time;
    end

    // key count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kc_reg <= CNT_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            kc_reg <= cfg_data;
        end
    end

    kvl_front u_front (.clk(clk), .rst_n(rst_n), .push(start && !full),
        .push_item(in_item), .full(full), .pop(pop), .empty(empty), .head(head));

    kvl_back u_back (.clk(clk), .rst_n(rst_n), .empty(empty), .head(head), .pop(pop),
        .key_count(kc_reg), .done(done), .out_x(out_x), .out_y(out_y), .out_z(out_z),
        .status(status));

endmodule

// ===== rtl/kvl_checker.sv =====
//==============================================================================
// kvl_checker
// Port-level checks for the keyframe interpolator.
//==============================================================================
module kvl_checker
    import kvl_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic        status,
    input logic [31:0] out_x,
    input logic        cfg_ready
);

    // a result is a single-cycle strobe
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("done held two cycles");

    // error results carry zero vectors (x component checked)
    assert property (@(posedge clk) disable iff (!rst_n) done && status |-> out_x == '0)
        else $error("error result not zero");

    // config always taken
    assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("cfg not ready");

    // busy only rises after an accepted item
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start && !busy))
        else $error("busy rose without an item");

    // no result right after reset
    assert property (@(posedge clk) $rose(rst_n) |-> !done)
        else $error("result after reset");

endmodule

bind keyframe_vector_lerp kvl_checker u_kvl_checker (.clk(clk), .rst_n(rst_n),
    .start(start), .busy(busy), .done(done), .status(status), .out_x(out_x),
    .cfg_ready(cfg_ready));
